### src/bpqlt_pkg.sv
// Shared types and constants for the buffer pool and queue load tracker.
// Holds event kinds, status codes, register indexes and the divider request types.
// No dependencies.
package bpqlt_pkg;

  // Field widths fixed by the event and result formats
  localparam int OFFSET_W  = 19;
  localparam int CNT_W     = 8;
  localparam int LOAD_W    = 18;
  localparam int STATUS_W  = 2;
  localparam int KIND_W    = 3;

  // Bitmap row geometry: eight slots per memory word
  localparam int ROW_W     = 8;
  localparam int ROW_BIT_W = 3;

  // Restoring divider: 19-bit dividend, divisor up to 131071
  localparam int DIV_NUM_W = 19;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_CNT_W = 5;

  // Configuration port
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [1:0] REG_SHED_LIMIT  = 2'd0;
  localparam logic [1:0] REG_BLOCK_LIMIT = 2'd1;
  localparam logic [1:0] REG_POOL_SIZE   = 2'd2;

  localparam logic [CNT_W-1:0] SHED_LIMIT_RST  = 8'd64;
  localparam logic [CNT_W-1:0] BLOCK_LIMIT_RST = 8'd72;
  localparam logic [CNT_W-1:0] POOL_SIZE_RST   = 8'd93;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_BUF  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_REL = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC    = 3'd0,
    KIND_RELEASE  = 3'd1,
    KIND_SENT     = 3'd2,
    KIND_COMPLETE = 3'd3,
    KIND_CLR_PEAK = 3'd4
  } kind_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

### src/bpqlt_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Forms the load figure from the in-flight count and the block limit.
// Depends on bpqlt_pkg.
module bpqlt_div import bpqlt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  assign shifted = {rem_r, num_r[DIV_NUM_W-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      num_nxt = req.num;
      den_nxt = req.den;
      rem_nxt = '0;
      cnt_nxt = DIV_CNT_W'(DIV_NUM_W);
    end else if (cnt_r != '0) begin
      // shift the dividend out at the top, the quotient bit in at the bottom
      rem_nxt  = ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      num_nxt  = {num_r[DIV_NUM_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

endmodule

### src/buffer_pool_and_queue_load_tracker.sv
// Buffer pool allocator with in-flight request load tracking.
// Top level: bitmap memory, event sequencer, config registers; uses bpqlt_div.
// Depends on bpqlt_pkg.
//
//  port group   direction  handshake                 carries
//  in_*         input      in_valid / in_stall       event: kind, offset, has_buffer
//  out_*        output     out_valid / out_stall     result: status, offset, counts, flags, load
//  APB (p*)     input      psel & penable, pready=1  shed_limit, block_limit, pool_size
//
// One event at a time; in_stall is high from acceptance until the result is staged.
// Counter events (send, complete without buffer, clear peak) go from acceptance
// through S_LOAD and S_LDIV, where the 19-step divider forms the load, to S_DONE.
// Allocate scans the bitmap one 8-slot row at a time in S_ACHK; a release passes
// S_SDIV for the offset-to-slot reciprocal multiply and S_RCHK for the row read.
// Synchronous reset sets the state, counters, limits and output valid, and clears every bitmap row valid bit.
// A staged result waits in the output register while out_stall is high.
module buffer_pool_and_queue_load_tracker import bpqlt_pkg::*; #(
  parameter int SLOTS       = 128,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [OFFSET_W-1:0] in_offset,
  input  logic                in_has_buffer,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [OFFSET_W-1:0] out_granted_offset,
  output logic [CNT_W-1:0]    out_used_count,
  output logic [CNT_W-1:0]    out_peak_used,
  output logic [CNT_W-1:0]    out_pending,
  output logic                out_shed,
  output logic                out_queue_full,
  output logic                out_must_drain,
  output logic [LOAD_W-1:0]   out_load_permille,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  localparam int ROWS_USED  = (SLOTS + ROW_W - 1) / ROW_W;
  localparam int ROW_IDX_W  = (ROWS_USED > 2) ? $clog2(ROWS_USED) : 1;
  localparam int ROWS       = 1 << ROW_IDX_W;
  localparam int SLOT_IDX_W = ROW_IDX_W + ROW_BIT_W;
  localparam int USE_W      = SLOT_IDX_W + 1;
  localparam int CMP_W      = (USE_W > CNT_W) ? USE_W : CNT_W;
  localparam int PROD_W     = SLOT_IDX_W + DIV_DEN_W;

  // offset / BLOCK_BYTES as a reciprocal multiply, exact over every 19-bit offset
  localparam int BLK_SH     = $clog2(BLOCK_BYTES);
  localparam int REC_SH     = OFFSET_W + BLK_SH;
  localparam int REC_W      = OFFSET_W + 2;
  localparam int REC_PROD_W = OFFSET_W + REC_W;
  localparam longint unsigned REC_M =
    ((64'd1 << REC_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ACHK = 7'b0000010,
    S_SDIV = 7'b0000100,
    S_RCHK = 7'b0001000,
    S_LOAD = 7'b0010000,
    S_LDIV = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic                  alloc_ok_r, alloc_ok_nxt;
  logic [SLOT_IDX_W-1:0] slot_r, slot_nxt;
  logic [ROW_IDX_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic [OFFSET_W-1:0]   off_r, off_nxt;
  logic [OFFSET_W-1:0]   granted_r, granted_nxt;
  logic [LOAD_W-1:0]     load_r, load_nxt;
  logic [CNT_W-1:0]      busy_total_r, busy_total_nxt;
  logic [CNT_W-1:0]      busy_peak_r, busy_peak_nxt;
  logic [CNT_W-1:0]      in_flight_r, in_flight_nxt;
  logic [CNT_W-1:0]      shed_limit_r, shed_limit_nxt;
  logic [CNT_W-1:0]      block_limit_r, block_limit_nxt;
  logic [CNT_W-1:0]      pool_size_r, pool_size_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [OFFSET_W-1:0]   out_granted_r, out_granted_nxt;
  logic [CNT_W-1:0]      out_used_r, out_used_nxt;
  logic [CNT_W-1:0]      out_peak_r, out_peak_nxt;
  logic [CNT_W-1:0]      out_pending_r, out_pending_nxt;
  logic                  out_shed_r, out_shed_nxt;
  logic                  out_full_r, out_full_nxt;
  logic                  out_drain_r, out_drain_nxt;
  logic [LOAD_W-1:0]     out_load_r, out_load_nxt;

  // bitmap memory, one word per row of slots
  logic [ROW_W-1:0]      bitmap_mem [ROWS];
  logic [ROWS-1:0]       row_vld_r;
  logic [ROW_W-1:0]      rd_data_r;
  logic                  rd_vld_r;
  logic [ROW_IDX_W-1:0]  rd_addr;
  logic                  mem_we;
  logic [ROW_IDX_W-1:0]  mem_waddr;
  logic [ROW_W-1:0]      mem_wdata;
  logic [ROW_W-1:0]      row_eff;

  logic [CMP_W-1:0]      pool_ext;
  logic [CMP_W-1:0]      usable_cmp;
  logic [USE_W-1:0]      usable;
  logic [ROW_W-1:0]      free_vec;
  logic                  free_found;
  logic [ROW_BIT_W-1:0]  free_idx;
  logic [USE_W-1:0]      next_base;
  logic                  last_row;
  logic [ROW_BIT_W-1:0]  rel_bit;
  logic [PROD_W-1:0]     grant_prod;
  logic [REC_PROD_W-1:0] rec_prod;
  logic [OFFSET_W-1:0]   rel_quo;
  logic [LOAD_W-1:0]     load_num;
  logic                  cfg_wr;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  bpqlt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // usable pool is min(pool_size, SLOTS)
  assign pool_ext   = CMP_W'(pool_size_r);
  assign usable_cmp = (pool_ext < CMP_W'(SLOTS)) ? pool_ext : CMP_W'(SLOTS);
  assign usable     = usable_cmp[USE_W-1:0];

  // a row never written reads as all free
  assign row_eff = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      free_vec[b] = !row_eff[b] &&
                    (USE_W'({row_cnt_r, ROW_BIT_W'(b)}) < usable);
    end
    free_found = 1'b0;
    free_idx   = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        free_found = 1'b1;
        free_idx   = ROW_BIT_W'(b);
      end
    end
  end

  assign next_base = USE_W'({row_cnt_r, ROW_BIT_W'(0)}) + USE_W'(ROW_W);
  assign last_row  = (next_base >= usable) || (row_cnt_r == '1);
  assign rel_bit   = slot_r[ROW_BIT_W-1:0];

  assign grant_prod = PROD_W'(slot_r) * PROD_W'(BLOCK_BYTES);

  assign rec_prod = REC_PROD_W'(off_r) * REC_PROD_W'(REC_M);
  assign rel_quo  = OFFSET_W'(rec_prod >> REC_SH);

  // in_flight * 1000 as shifts and subtracts
  assign load_num = {in_flight_r, 10'b0} - LOAD_W'({in_flight_r, 4'b0})
                    - LOAD_W'({in_flight_r, 3'b0});

  always_comb begin
    case (state_r)
      S_ACHK:  rd_addr = row_cnt_r + 1'b1;
      S_SDIV:  rd_addr = rel_quo[SLOT_IDX_W-1:ROW_BIT_W];
      S_IDLE:  rd_addr = '0;
      default: rd_addr = row_cnt_r;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    status_nxt      = status_r;
    alloc_ok_nxt    = alloc_ok_r;
    slot_nxt        = slot_r;
    row_cnt_nxt     = row_cnt_r;
    off_nxt         = off_r;
    granted_nxt     = granted_r;
    load_nxt        = load_r;
    busy_total_nxt  = busy_total_r;
    busy_peak_nxt   = busy_peak_r;
    in_flight_nxt   = in_flight_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_used_nxt    = out_used_r;
    out_peak_nxt    = out_peak_r;
    out_pending_nxt = out_pending_r;
    out_shed_nxt    = out_shed_r;
    out_full_nxt    = out_full_r;
    out_drain_nxt   = out_drain_r;
    out_load_nxt    = out_load_r;
    mem_we          = 1'b0;
    mem_waddr       = row_cnt_r;
    mem_wdata       = row_eff;
    div_req.start   = 1'b0;
    div_req.num     = '0;
    div_req.den     = '0;

    // drop the staged result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt     = kind_t'(in_kind);
          status_nxt   = STAT_OK;
          alloc_ok_nxt = 1'b0;
          row_cnt_nxt  = '0;
          off_nxt      = in_offset;
          state_nxt    = S_LOAD;
          case (kind_t'(in_kind))
            KIND_ALLOC: begin
              state_nxt = S_ACHK;
            end
            KIND_RELEASE: begin
              state_nxt = S_SDIV;
            end
            KIND_SENT: begin
              if (in_flight_r != '1) begin
                in_flight_nxt = in_flight_r + 1'b1;
              end
            end
            KIND_COMPLETE: begin
              if (in_has_buffer) begin
                state_nxt = S_SDIV;
              end else if (in_flight_r != '0) begin
                in_flight_nxt = in_flight_r - 1'b1;
              end
            end
            KIND_CLR_PEAK: begin
              busy_peak_nxt = '0;
            end
            default: begin
              state_nxt = S_LOAD;
            end
          endcase
        end
      end

      S_ACHK: begin
        if (free_found) begin
          mem_we              = 1'b1;
          mem_wdata[free_idx] = 1'b1;
          slot_nxt            = {row_cnt_r, free_idx};
          alloc_ok_nxt        = 1'b1;
          busy_total_nxt      = busy_total_r + 1'b1;
          if (busy_peak_r < busy_total_nxt) begin
            busy_peak_nxt = busy_total_nxt;
          end
          state_nxt = S_LOAD;
        end else if (last_row) begin
          status_nxt = STAT_NO_BUF;
          state_nxt  = S_LOAD;
        end else begin
          row_cnt_nxt = row_cnt_r + 1'b1;
        end
      end

      S_SDIV: begin
        if (rel_quo < OFFSET_W'(usable)) begin
          slot_nxt    = rel_quo[SLOT_IDX_W-1:0];
          row_cnt_nxt = rel_quo[SLOT_IDX_W-1:ROW_BIT_W];
          state_nxt   = S_RCHK;
        end else begin
          status_nxt = STAT_BAD_REL;
          state_nxt  = S_LOAD;
        end
      end

      S_RCHK: begin
        if (row_eff[rel_bit]) begin
          mem_we             = 1'b1;
          mem_wdata[rel_bit] = 1'b0;
          if (busy_total_r != '0) begin
            busy_total_nxt = busy_total_r - 1'b1;
          end
          if (kind_r == KIND_COMPLETE && in_flight_r != '0) begin
            in_flight_nxt = in_flight_r - 1'b1;
          end
        end else begin
          status_nxt = STAT_BAD_REL;
        end
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(load_num);
        div_req.den   = (block_limit_r == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(block_limit_r);
        granted_nxt   = alloc_ok_r ? grant_prod[OFFSET_W-1:0] : '0;
        state_nxt     = S_LDIV;
      end

      S_LDIV: begin
        if (div_rsp.done) begin
          load_nxt  = div_rsp.quo[LOAD_W-1:0];
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_granted_nxt = granted_r;
          out_used_nxt    = busy_total_r;
          out_peak_nxt    = busy_peak_r;
          out_pending_nxt = in_flight_r;
          out_shed_nxt    = in_flight_r > shed_limit_r;
          out_full_nxt    = in_flight_r >= block_limit_r;
          out_drain_nxt   = in_flight_r > block_limit_r;
          out_load_nxt    = load_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // configuration registers
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    shed_limit_nxt  = shed_limit_r;
    block_limit_nxt = block_limit_r;
    pool_size_nxt   = pool_size_r;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_SHED_LIMIT:  shed_limit_nxt  = pwdata[CNT_W-1:0];
        REG_BLOCK_LIMIT: block_limit_nxt = pwdata[CNT_W-1:0];
        REG_POOL_SIZE:   pool_size_nxt   = pwdata[CNT_W-1:0];
        default: begin
          shed_limit_nxt = shed_limit_r;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SHED_LIMIT:  prdata = APB_DW'(shed_limit_r);
      REG_BLOCK_LIMIT: prdata = APB_DW'(block_limit_r);
      REG_POOL_SIZE:   prdata = APB_DW'(pool_size_r);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      busy_total_r  <= '0;
      busy_peak_r   <= '0;
      in_flight_r   <= '0;
      shed_limit_r  <= SHED_LIMIT_RST;
      block_limit_r <= BLOCK_LIMIT_RST;
      pool_size_r   <= POOL_SIZE_RST;
      out_valid_r   <= 1'b0;
      row_vld_r     <= '0;
      rd_vld_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      busy_total_r  <= busy_total_nxt;
      busy_peak_r   <= busy_peak_nxt;
      in_flight_r   <= in_flight_nxt;
      shed_limit_r  <= shed_limit_nxt;
      block_limit_r <= block_limit_nxt;
      pool_size_r   <= pool_size_nxt;
      out_valid_r   <= out_valid_nxt;
      rd_vld_r      <= row_vld_r[rd_addr];
      if (mem_we) begin
        row_vld_r[mem_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    status_r      <= status_nxt;
    alloc_ok_r    <= alloc_ok_nxt;
    slot_r        <= slot_nxt;
    row_cnt_r     <= row_cnt_nxt;
    off_r         <= off_nxt;
    granted_r     <= granted_nxt;
    load_r        <= load_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_used_r    <= out_used_nxt;
    out_peak_r    <= out_peak_nxt;
    out_pending_r <= out_pending_nxt;
    out_shed_r    <= out_shed_nxt;
    out_full_r    <= out_full_nxt;
    out_drain_r   <= out_drain_nxt;
    out_load_r    <= out_load_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= bitmap_mem[rd_addr];
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_offset = out_granted_r;
  assign out_used_count     = out_used_r;
  assign out_peak_used      = out_peak_r;
  assign out_pending        = out_pending_r;
  assign out_shed           = out_shed_r;
  assign out_queue_full     = out_full_r;
  assign out_must_drain     = out_drain_r;
  assign out_load_permille  = out_load_r;

endmodule

### verif/tb_buffer_pool_and_queue_load_tracker.sv
`timescale 1ns / 1ps
// Self-checking bench for buffer_pool_and_queue_load_tracker: drives events and limits,
// predicts every result in a ledger class and compares field by field.
// Depends on bpqlt_pkg and the block's top level.
module tb_buffer_pool_and_queue_load_tracker import bpqlt_pkg::*; ();

  localparam int POOL_SLOTS = 128;
  localparam int BUF_BYTES  = 4096;
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] granted;
    logic [CNT_W-1:0]    used;
    logic [CNT_W-1:0]    peak;
    logic [CNT_W-1:0]    pending;
    logic                shed;
    logic                full;
    logic                drain;
    logic [LOAD_W-1:0]   load;
  } pool_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [OFFSET_W-1:0] in_offset = '0;
  logic                in_has_buffer = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [OFFSET_W-1:0] out_granted_offset;
  logic [CNT_W-1:0]    out_used_count;
  logic [CNT_W-1:0]    out_peak_used;
  logic [CNT_W-1:0]    out_pending;
  logic                out_shed;
  logic                out_queue_full;
  logic                out_must_drain;
  logic [LOAD_W-1:0]   out_load_permille;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  buffer_pool_and_queue_load_tracker #(
    .SLOTS(POOL_SLOTS),
    .BLOCK_BYTES(BUF_BYTES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_offset(in_offset),
    .in_has_buffer(in_has_buffer),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_granted_offset(out_granted_offset),
    .out_used_count(out_used_count),
    .out_peak_used(out_peak_used),
    .out_pending(out_pending),
    .out_shed(out_shed),
    .out_queue_full(out_queue_full),
    .out_must_drain(out_must_drain),
    .out_load_permille(out_load_permille),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Mirror of the pool bitmap, counters and limits; holds the results still owed.
  class pool_ledger;
    bit [CNT_W-1:0] shed_lim;
    bit [CNT_W-1:0] blk_lim;
    bit [CNT_W-1:0] pool_sz;
    bit             slot_used[POOL_SLOTS];
    bit [CNT_W-1:0] used_total;
    bit [CNT_W-1:0] used_peak;
    bit [CNT_W-1:0] inflight;
    bit [CNT_W-1:0] inflight_top;
    pool_result_t   awaited[$];
    int unsigned    mismatches;
    int unsigned    checked;
    int unsigned    kind_hits[1 << KIND_W];
    int unsigned    status_hits[1 << STATUS_W];

    function new();
      shed_lim = SHED_LIMIT_RST;
      blk_lim  = BLOCK_LIMIT_RST;
      pool_sz  = POOL_SIZE_RST;
    endfunction

    function void set_limit(logic [1:0] idx, logic [CNT_W-1:0] val);
      case (idx)
        REG_SHED_LIMIT:  shed_lim = val;
        REG_BLOCK_LIMIT: blk_lim = val;
        REG_POOL_SIZE:   pool_sz = val;
        default: ;
      endcase
    endfunction

    function int unsigned usable_slots();
      return (pool_sz < POOL_SLOTS) ? pool_sz : POOL_SLOTS;
    endfunction

    // Free the slot holding this byte offset; refuse slots outside the pool or idle ones.
    function bit drop_buffer(logic [OFFSET_W-1:0] off);
      int unsigned idx;
      idx = off / BUF_BYTES;
      if (idx >= usable_slots() || !slot_used[idx]) return 1'b0;
      slot_used[idx] = 1'b0;
      if (used_total > 0) used_total--;
      return 1'b1;
    endfunction

    function void take_event(logic [KIND_W-1:0] k, logic [OFFSET_W-1:0] off, logic hb);
      pool_result_t r;
      bit found;
      r = '0;
      found = 1'b0;
      case (k)
        KIND_ALLOC: begin
          for (int i = 0; i < usable_slots() && !found; i++) begin
            if (!slot_used[i]) begin
              found = 1'b1;
              slot_used[i] = 1'b1;
              r.granted = OFFSET_W'(i * BUF_BYTES);
              used_total++;
              if (used_peak < used_total) used_peak = used_total;
            end
          end
          if (!found) r.status = STAT_NO_BUF;
        end
        KIND_RELEASE: begin
          if (!drop_buffer(off)) r.status = STAT_BAD_REL;
        end
        KIND_SENT: begin
          if (inflight != '1) inflight++;
        end
        KIND_COMPLETE: begin
          // a bad buffer on completion leaves the in-flight count alone
          if (hb && !drop_buffer(off)) r.status = STAT_BAD_REL;
          else if (inflight != 0) inflight--;
        end
        KIND_CLR_PEAK: used_peak = '0;
        default: ;
      endcase
      r.used    = used_total;
      r.peak    = used_peak;
      r.pending = inflight;
      r.shed    = inflight > shed_lim;
      r.full    = inflight >= blk_lim;
      r.drain   = inflight > blk_lim;
      r.load    = LOAD_W'((32'(inflight) * 1000) / ((blk_lim == 0) ? 1 : 32'(blk_lim)));
      if (inflight > inflight_top) inflight_top = inflight;
      kind_hits[k]++;
      status_hits[r.status]++;
      awaited.insert(awaited.size(), r);
    endfunction

    function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (got === want) return 1'b1;
      if (mismatches < 10)
        $display("result %0d at %0t: %s expected %0d got %0d", checked, $time, name, want, got);
      return 1'b0;
    endfunction

    function void match_result(pool_result_t got);
      pool_result_t want;
      bit ok;
      if (awaited.size() == 0) begin
        if (mismatches < 10) $display("result at %0t with nothing awaited", $time);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      ok = field_ok("status", 32'(want.status), 32'(got.status));
      ok &= field_ok("granted_offset", 32'(want.granted), 32'(got.granted));
      ok &= field_ok("used_count", 32'(want.used), 32'(got.used));
      ok &= field_ok("peak_used", 32'(want.peak), 32'(got.peak));
      ok &= field_ok("pending", 32'(want.pending), 32'(got.pending));
      ok &= field_ok("shed", 32'(want.shed), 32'(got.shed));
      ok &= field_ok("queue_full", 32'(want.full), 32'(got.full));
      ok &= field_ok("must_drain", 32'(want.drain), 32'(got.drain));
      ok &= field_ok("load_permille", 32'(want.load), 32'(got.load));
      if (!ok) mismatches++;
    endfunction

    function int unsigned results_owed();
      return awaited.size();
    endfunction
  endclass

  pool_ledger ledger = new();

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_buffer_pool_and_queue_load_tracker NOT OK");
    $finish;
  end

  // Result side: check accepted results, then pick the stall for the next cycle.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall)
        ledger.match_result('{status: out_status, granted: out_granted_offset,
                              used: out_used_count, peak: out_peak_used,
                              pending: out_pending, shed: out_shed,
                              full: out_queue_full, drain: out_must_drain,
                              load: out_load_permille});
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_event(input logic [KIND_W-1:0] k, input logic [OFFSET_W-1:0] off,
                            input logic hb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= k;
    in_offset     <= off;
    in_has_buffer <= hb;
    do @(posedge clk); while (in_stall !== 1'b0);
    ledger.take_event(k, off, hb);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (ledger.results_owed() != 0 || in_stall === 1'b1) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(APB_DW - CNT_W){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ledger.set_limit(idx, val);
  endtask

  task automatic program_limits(input logic [CNT_W-1:0] shed, input logic [CNT_W-1:0] blk,
                                input logic [CNT_W-1:0] pool);
    wait_idle();
    write_reg(REG_SHED_LIMIT, shed);
    write_reg(REG_BLOCK_LIMIT, blk);
    write_reg(REG_POOL_SIZE, pool);
  endtask

  // Random events with a given mix; percentages left over go to clear peak and spare kinds.
  task automatic mix(input int unsigned n, input int unsigned p_alloc,
                     input int unsigned p_rel, input int unsigned p_sent,
                     input int unsigned p_done);
    int unsigned roll;
    int unsigned pick;
    logic [KIND_W-1:0] k;
    logic [OFFSET_W-1:0] off;
    logic hb;
    repeat (n) begin
      roll = $urandom_range(99);
      off  = OFFSET_W'($urandom);
      hb   = 1'($urandom);
      if (roll < p_alloc) k = KIND_ALLOC;
      else if (roll < p_alloc + p_rel) k = KIND_RELEASE;
      else if (roll < p_alloc + p_rel + p_sent) k = KIND_SENT;
      else if (roll < p_alloc + p_rel + p_sent + p_done) k = KIND_COMPLETE;
      else if (roll < 97) k = KIND_CLR_PEAK;
      else k = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      // aim most releases at a held buffer, at a random byte inside it
      if ((k == KIND_RELEASE || k == KIND_COMPLETE) && $urandom_range(99) < 75) begin
        pick = $urandom_range(POOL_SLOTS - 1);
        for (int j = 0; j < POOL_SLOTS; j++) begin
          if (ledger.slot_used[(pick + j) % POOL_SLOTS]) begin
            off = OFFSET_W'(((pick + j) % POOL_SLOTS) * BUF_BYTES
                            + $urandom_range(BUF_BYTES - 1));
            break;
          end
        end
      end
      send_event(k, off, hb);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 81;
    // reset limits: completion at zero, bad and good releases, lowest-free reuse
    send_event(KIND_COMPLETE, '0, 1'b0);
    send_event(KIND_RELEASE, '0, 1'b0);
    repeat (3) send_event(KIND_ALLOC, '0, 1'b0);
    send_event(KIND_RELEASE, OFFSET_W'(2 * BUF_BYTES - 1), 1'b1);
    send_event(KIND_ALLOC, '1, 1'b1);
    send_event(KIND_RELEASE, '1, 1'b0);
    send_event(KIND_RELEASE, OFFSET_W'(POOL_SIZE_RST * BUF_BYTES), 1'b0);
    send_event(KIND_RELEASE, OFFSET_W'((POOL_SIZE_RST - 1) * BUF_BYTES), 1'b0);
    repeat (2) send_event(KIND_SENT, '0, 1'b0);
    send_event(KIND_COMPLETE, OFFSET_W'(3 * BUF_BYTES), 1'b1);
    send_event(KIND_COMPLETE, '0, 1'b1);
    send_event(KIND_COMPLETE, '1, 1'b0);
    send_event(KIND_CLR_PEAK, '0, 1'b0);
    send_event(KIND_ALLOC, '0, 1'b0);
    for (int s = KIND_SPARE_LO; s <= KIND_SPARE_HI; s++) send_event(KIND_W'(s), '1, 1'b1);
    send_event(KIND_RELEASE, OFFSET_W'(2 * BUF_BYTES), 1'b0);
    send_event(KIND_RELEASE, OFFSET_W'(2 * BUF_BYTES), 1'b0);
    send_event(KIND_SENT, '1, 1'b1);
    send_event(KIND_COMPLETE, OFFSET_W'(BUF_BYTES), 1'b1);

    // one-slot pool with tightest limits; its only slot is still held from earlier
    program_limits(8'd0, 8'd1, 8'd1);
    mix(130, 30, 25, 20, 20);
    // widest limits and full pool: drive in-flight into saturation, then fill the pool
    program_limits(8'd255, 8'd255, 8'd128);
    repeat (260) send_event(KIND_SENT, OFFSET_W'($urandom), 1'($urandom));
    mix(350, 50, 5, 20, 15);

    send_idle_pct = 81;
    recv_idle_pct = 19;
    // zero block limit and empty pool
    program_limits(8'd10, 8'd0, 8'd0);
    mix(130, 10, 10, 5, 70);
    // shrunk pool with many buffers held above it
    program_limits(SHED_LIMIT_RST, BLOCK_LIMIT_RST, 8'd8);
    mix(130, 20, 10, 10, 55);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // pool size beyond the slot count; drain the held buffers
    program_limits(CNT_W'($urandom_range(255)), CNT_W'($urandom_range(1, 255)), 8'd255);
    mix(130, 10, 25, 10, 50);
    program_limits(8'd20, 8'd30, 8'd16);
    // hold results back long enough that the block stalls its input
    hold_req = 300;
    mix(130, 30, 25, 20, 20);

    wait_idle();
    repeat (60) @(posedge clk);

    $display("covered %0d events: alloc %0d, release %0d, sent %0d, complete %0d, clear %0d",
             ledger.checked, ledger.kind_hits[KIND_ALLOC], ledger.kind_hits[KIND_RELEASE],
             ledger.kind_hits[KIND_SENT], ledger.kind_hits[KIND_COMPLETE],
             ledger.kind_hits[KIND_CLR_PEAK]);
    $display("pool full %0d, bad release %0d, in-flight peak %0d, mismatches %0d",
             ledger.status_hits[STAT_NO_BUF], ledger.status_hits[STAT_BAD_REL],
             ledger.inflight_top, ledger.mismatches);
    if (ledger.mismatches == 0 && ledger.results_owed() == 0) begin
      $display("tb_buffer_pool_and_queue_load_tracker OK");
    end else begin
      $display("tb_buffer_pool_and_queue_load_tracker NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
src/bpqlt_pkg.sv
src/bpqlt_div.sv
src/buffer_pool_and_queue_load_tracker.sv
verif/tb_buffer_pool_and_queue_load_tracker.sv
